// ----- hdl/ksl_pkg.sv -----
// ----------------------------------------------------------------------------
// ksl_pkg
// Shared types, token codes and character classes for the keyword and
// symbol lexer.
// ----------------------------------------------------------------------------
package ksl_pkg;

  localparam int TEXT_CHARS = 8;
  localparam int COORD_BITS = 16;
  localparam int TEXT_BITS  = TEXT_CHARS * 8;
  localparam int TIDX_W     = $clog2(TEXT_CHARS);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] LEN_MAX    = 8'hFF;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TEXT_BITS-1:0]  text_t;
  typedef logic [7:0]            len_t;

  typedef enum logic [4:0] {
    TK_IDENT = 5'd0,
    TK_FN, TK_RETURN, TK_VAR, TK_FINAL, TK_I32, TK_F32, TK_STRING, TK_STRUCT,
    TK_SEMI, TK_LBRACE, TK_RBRACE, TK_LPAREN, TK_RPAREN, TK_STAR, TK_ASSIGN,
    TK_COMMA, TK_BANG, TK_LT, TK_GT,
    TK_ARROW, TK_LE, TK_GE, TK_NE, TK_ADD_EQ, TK_SUB_EQ, TK_MUL_EQ, TK_DIV_EQ,
    TK_EOF
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WORD = 3'b010,
    MODE_HELD = 3'b100
  } mode_t;

  typedef struct packed {
    tok_kind_t kind;
    coord_t    line;
    coord_t    col;
    len_t      len;
    text_t     text;
    logic      last;
  } tok_t;

  // Up to two tokens come out of one input beat; a lone token is always first.
  typedef struct packed {
    logic first_vld;
    logic second_vld;
    tok_t first;
    tok_t second;
  } tok_pair_t;

  typedef struct packed {
    logic      hit;
    tok_kind_t kind;
  } kind_hit_t;

  function automatic coord_t sat_inc(input coord_t v);
    return (v == '1) ? v : v + coord_t'(1);
  endfunction

  function automatic tok_t mk_tok(input tok_kind_t kind, input coord_t line,
                                  input coord_t col, input len_t len, input text_t text);
    tok_t t;
    t.kind = kind;
    t.line = line;
    t.col  = col;
    t.len  = len;
    t.text = text;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return b inside {["A":"Z"], ["a":"z"], ["0":"9"], "_"};
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};
  endfunction

  function automatic logic starts_double(input logic [7:0] b);
    return b inside {"-", "<", ">", "!", "+", "*", "/"};
  endfunction

  function automatic kind_hit_t single_of(input logic [7:0] b);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = TK_IDENT;
    case (b)
      ";":     r.kind = TK_SEMI;
      "{":     r.kind = TK_LBRACE;
      "}":     r.kind = TK_RBRACE;
      "(":     r.kind = TK_LPAREN;
      ")":     r.kind = TK_RPAREN;
      "*":     r.kind = TK_STAR;
      "=":     r.kind = TK_ASSIGN;
      ",":     r.kind = TK_COMMA;
      "!":     r.kind = TK_BANG;
      "<":     r.kind = TK_LT;
      ">":     r.kind = TK_GT;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t double_of(input logic [7:0] a, input logic [7:0] b);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = TK_IDENT;
    case ({a, b})
      "->":    r.kind = TK_ARROW;
      "<=":    r.kind = TK_LE;
      ">=":    r.kind = TK_GE;
      "!=":    r.kind = TK_NE;
      "+=":    r.kind = TK_ADD_EQ;
      "-=":    r.kind = TK_SUB_EQ;
      "*=":    r.kind = TK_MUL_EQ;
      "/=":    r.kind = TK_DIV_EQ;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // The keyword string is right-aligned in s (last character lowest), while
  // the word text holds its first character in the lowest byte.
  function automatic logic kw_match(input text_t t, input len_t n_have,
                                    input logic [47:0] s, input int n);
    logic ok;
    int   idx;
    ok = (n_have == len_t'(n));
    for (int j = 0; j < 6; j++) begin
      idx = (j < n) ? (n - 1 - j) : 0;
      if (j < n && t[8*j +: 8] != s[8*idx +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic tok_kind_t word_kind(input text_t t, input len_t n);
    tok_kind_t k;
    k = TK_IDENT;
    if (kw_match(t, n, 48'("fn"), 2)) begin
      k = TK_FN;
    end else if (kw_match(t, n, 48'("return"), 6)) begin
      k = TK_RETURN;
    end else if (kw_match(t, n, 48'("var"), 3)) begin
      k = TK_VAR;
    end else if (kw_match(t, n, 48'("final"), 5)) begin
      k = TK_FINAL;
    end else if (kw_match(t, n, 48'("i32"), 3)) begin
      k = TK_I32;
    end else if (kw_match(t, n, 48'("f32"), 3)) begin
      k = TK_F32;
    end else if (kw_match(t, n, 48'("string"), 6)) begin
      k = TK_STRING;
    end else if (kw_match(t, n, 48'("struct"), 6)) begin
      k = TK_STRUCT;
    end
    return k;
  endfunction

endpackage

// ----- hdl/ksl_scan.sv -----
// ----------------------------------------------------------------------------
// ksl_scan
// Scanner state and the per-byte step that yields up to two tokens per beat.
// ----------------------------------------------------------------------------
module ksl_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                end_of_input,
  input  logic [7:0]          byte_in,
  output ksl_pkg::tok_pair_t  toks
);

  ksl_pkg::mode_t  mode_r,  mode_nxt;
  logic [7:0]      held_r,  held_nxt;
  ksl_pkg::text_t  wtext_r, wtext_nxt;
  ksl_pkg::len_t   wlen_r,  wlen_nxt;
  ksl_pkg::coord_t tscol_r, tscol_nxt;
  ksl_pkg::coord_t line_r,  line_nxt;
  ksl_pkg::coord_t col_r,   col_nxt;

  ksl_pkg::tok_t      flush_tok, fresh_tok, tok_a, tok_b;
  logic               flush_vld, vld_a, vld_b;
  ksl_pkg::kind_hit_t held_single, byte_single, dbl;

  assign held_single = ksl_pkg::single_of(held_r);
  assign byte_single = ksl_pkg::single_of(byte_in);
  assign dbl         = ksl_pkg::double_of(held_r, byte_in);

  // Token left pending by the previous beats, if any.
  always_comb begin
    flush_vld = 1'b0;
    flush_tok = ksl_pkg::mk_tok(ksl_pkg::TK_IDENT, line_r, tscol_r, '0, '0);
    case (mode_r)
      ksl_pkg::MODE_WORD: begin
        flush_vld = 1'b1;
        flush_tok = ksl_pkg::mk_tok(ksl_pkg::word_kind(wtext_r, wlen_r), line_r, tscol_r,
                                    wlen_r, wtext_r);
      end
      ksl_pkg::MODE_HELD: begin
        // A held plus, minus or slash has no single form and is dropped.
        flush_vld = held_single.hit;
        flush_tok = ksl_pkg::mk_tok(held_single.kind, line_r, tscol_r, '0, '0);
      end
      default: begin
        flush_vld = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    wtext_nxt = wtext_r;
    wlen_nxt  = wlen_r;
    tscol_nxt = tscol_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    vld_a     = 1'b0;
    vld_b     = 1'b0;
    tok_a     = flush_tok;
    fresh_tok = ksl_pkg::mk_tok(ksl_pkg::TK_EOF, line_r, col_r, '0, '0);

    if (end_of_input) begin
      vld_a     = flush_vld;
      vld_b     = 1'b1;
      mode_nxt  = ksl_pkg::MODE_IDLE;
      held_nxt  = '0;
      wtext_nxt = '0;
      wlen_nxt  = '0;
      tscol_nxt = ksl_pkg::coord_t'(1);
      line_nxt  = ksl_pkg::coord_t'(1);
      col_nxt   = ksl_pkg::coord_t'(1);
    end else if (mode_r == ksl_pkg::MODE_WORD && ksl_pkg::is_word(byte_in)) begin
      if (wlen_r < ksl_pkg::len_t'(ksl_pkg::TEXT_CHARS)) begin
        wtext_nxt[8*wlen_r[ksl_pkg::TIDX_W-1:0] +: 8] = byte_in;
      end
      if (wlen_r != ksl_pkg::LEN_MAX) begin
        wlen_nxt = wlen_r + 8'd1;
      end
      col_nxt = ksl_pkg::sat_inc(col_r);
    end else if (mode_r == ksl_pkg::MODE_HELD && dbl.hit) begin
      vld_b     = 1'b1;
      fresh_tok = ksl_pkg::mk_tok(dbl.kind, line_r, tscol_r, '0, '0);
      mode_nxt  = ksl_pkg::MODE_IDLE;
      held_nxt  = '0;
      col_nxt   = ksl_pkg::sat_inc(col_r);
    end else begin
      vld_a     = flush_vld;
      mode_nxt  = ksl_pkg::MODE_IDLE;
      held_nxt  = '0;
      wtext_nxt = '0;
      wlen_nxt  = '0;
      if (byte_in == ksl_pkg::CH_NEWLINE) begin
        line_nxt = ksl_pkg::sat_inc(line_r);
        col_nxt  = ksl_pkg::coord_t'(1);
      end else begin
        col_nxt = ksl_pkg::sat_inc(col_r);
        if (ksl_pkg::is_blank(byte_in)) begin
          col_nxt = ksl_pkg::sat_inc(col_r);
        end else if (ksl_pkg::starts_double(byte_in)) begin
          held_nxt  = byte_in;
          tscol_nxt = col_r;
          mode_nxt  = ksl_pkg::MODE_HELD;
        end else if (byte_single.hit) begin
          vld_b     = 1'b1;
          fresh_tok = ksl_pkg::mk_tok(byte_single.kind, line_r, col_r, '0, '0);
        end else if (ksl_pkg::is_word(byte_in)) begin
          wtext_nxt = ksl_pkg::text_t'(byte_in);
          wlen_nxt  = 8'd1;
          tscol_nxt = col_r;
          mode_nxt  = ksl_pkg::MODE_WORD;
        end
      end
    end

    tok_b = fresh_tok;
  end

  // Pack so that a single token always lands in the first slot.
  always_comb begin
    toks.first_vld  = vld_a | vld_b;
    toks.second_vld = vld_a & vld_b;
    toks.first      = vld_a ? tok_a : tok_b;
    toks.second     = tok_b;
    toks.first.last = ~(vld_a & vld_b);
    toks.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ksl_pkg::MODE_IDLE;
      held_r  <= '0;
      wtext_r <= '0;
      wlen_r  <= '0;
      tscol_r <= ksl_pkg::coord_t'(1);
      line_r  <= ksl_pkg::coord_t'(1);
      col_r   <= ksl_pkg::coord_t'(1);
    end else if (step) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      wtext_r <= wtext_nxt;
      wlen_r  <= wlen_nxt;
      tscol_r <= tscol_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
    end
  end

  a_word_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == ksl_pkg::MODE_WORD |-> wlen_r != '0)
    else $error("word mode with zero length");

  a_held_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == ksl_pkg::MODE_HELD |-> ksl_pkg::starts_double(held_r))
    else $error("held mode without an operator lead byte");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == ksl_pkg::MODE_IDLE |-> (wlen_r == '0 && held_r == '0 && wtext_r == '0))
    else $error("idle mode with leftover token state");

endmodule

// ----- hdl/ksl_queue.sv -----
// ----------------------------------------------------------------------------
// ksl_queue
// Four-entry token queue that takes up to two tokens per beat and hands out
// one per beat.
// ----------------------------------------------------------------------------
module ksl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ksl_pkg::tok_pair_t pair,
  output logic               room,
  output logic               head_vld,
  input  logic               head_rdy,
  output ksl_pkg::tok_t      head
);

  ksl_pkg::tok_t                ent_r [ksl_pkg::QDEPTH];
  logic [ksl_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ksl_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ksl_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ksl_pkg::QPTR_W-1:0]   wr_ptr_p1;
  logic                         push_a, push_b, pop;

  assign push_a    = push & pair.first_vld;
  assign push_b    = push & pair.second_vld;
  assign pop       = head_vld & head_rdy;
  assign wr_ptr_p1 = wr_ptr_r + ksl_pkg::QPTR_W'(1);

  // Room for two tokens is required before taking a beat.
  assign room     = cnt_r <= ksl_pkg::QCNT_W'(ksl_pkg::QDEPTH - 2);
  assign head_vld = cnt_r != '0;
  assign head     = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ksl_pkg::QPTR_W'(push_a) + ksl_pkg::QPTR_W'(push_b);
    rd_ptr_nxt = rd_ptr_r + ksl_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + ksl_pkg::QCNT_W'(push_a) + ksl_pkg::QCNT_W'(push_b)
                 - ksl_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      ent_r[wr_ptr_r] <= pair.first;
    end
    if (push_b) begin
      ent_r[wr_ptr_p1] <= pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ksl_pkg::QCNT_W'(ksl_pkg::QDEPTH))
    else $error("token queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> push_a)
    else $error("second token pushed without a first");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    ksl_pkg::QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[ksl_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with the fill count");

endmodule

// ----- hdl/keyword_symbol_lexer.sv -----
// ----------------------------------------------------------------------------
// keyword_symbol_lexer
// Streaming lexer: source bytes in, tokens with kind and start position out.
// ----------------------------------------------------------------------------
// A beat that completes a token writes it into the token queue, which feeds
// the out_ channel. Throughput: one input beat per cycle, but in_ready drops
// while the queue holds more than two tokens; a beat yields zero, one or two
// tokens; the four-entry queue drains one per cycle while out_ready is high.
// Reset (synchronous, rst_n low) empties the queue and returns the scanner to
// line 1, column 1 with nothing pending.
module keyword_symbol_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [7:0]  out_text_length,
  output logic [63:0] out_text_bytes,
  output logic        out_last_of_run
);

  ksl_pkg::tok_pair_t toks;
  ksl_pkg::tok_t      head;
  logic               step;
  logic               room;

  assign in_ready = room;
  assign step     = in_valid & in_ready;

  ksl_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .end_of_input (in_action),
    .byte_in      (in_source_byte),
    .toks         (toks)
  );

  ksl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .pair     (toks),
    .room     (room),
    .head_vld (out_valid),
    .head_rdy (out_ready),
    .head     (head)
  );

  assign out_token_kind   = 5'(head.kind);
  assign out_start_line   = 16'(head.line);
  assign out_start_column = 16'(head.col);
  assign out_text_length  = head.len;
  assign out_text_bytes   = 64'(head.text);
  assign out_last_of_run  = head.last;

endmodule
